### rtl/cmfs_pkg.sv
// ----------------------------------------------------------------------------
// cmfs_pkg
// Shared types and constants for the cube map face select unit: transaction
// payloads, face codes and the record that travels down the divider chain.
// ----------------------------------------------------------------------------
package cmfs_pkg;

  // direction component width and fraction width of the face coordinates
  localparam int CMFS_COORD_BITS = 16;
  localparam int CMFS_FRAC_BITS  = 16;

  // face codes
  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  // face center and full span in Q1.FRAC_BITS
  localparam logic [CMFS_FRAC_BITS:0] CMFS_HALF =
    (CMFS_FRAC_BITS+1)'(1) << (CMFS_FRAC_BITS - 1);
  localparam logic [CMFS_FRAC_BITS:0] CMFS_ONE =
    (CMFS_FRAC_BITS+1)'(1) << CMFS_FRAC_BITS;

  // input transaction
  typedef struct packed {
    logic signed [CMFS_COORD_BITS-1:0] dir_x;
    logic signed [CMFS_COORD_BITS-1:0] dir_y;
    logic signed [CMFS_COORD_BITS-1:0] dir_z;
  } cmfs_in_t;

  // output transaction
  typedef struct packed {
    logic [2:0]                face;
    logic [CMFS_FRAC_BITS:0]   coord_s;
    logic [CMFS_FRAC_BITS:0]   coord_t;
    logic                      zero_vector;
  } cmfs_out_t;

  // one coordinate lane of the divider: partial remainder, quotient so far
  typedef struct packed {
    logic [CMFS_COORD_BITS-1:0] trial;
    logic [CMFS_FRAC_BITS-1:0]  quo;
    logic                       neg;
  } cmfs_lane_t;

  // record handed from cell to cell
  typedef struct packed {
    logic [2:0]                 face;
    logic                       zero;
    logic [CMFS_COORD_BITS-1:0] ma;
    cmfs_lane_t                 s;
    cmfs_lane_t                 t;
  } cmfs_cell_t;

endpackage

### rtl/cmfs_front.sv
// ----------------------------------------------------------------------------
// cmfs_front
// Major axis selection: magnitudes, face code, and the s/t numerator
// magnitudes and signs from the sign table. Registered into the chain.
// ----------------------------------------------------------------------------
module cmfs_front
  import cmfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  cmfs_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output cmfs_cell_t out_data
);

  localparam int C = CMFS_COORD_BITS;

  logic [C-1:0] ux, uy, uz;
  logic [C-1:0] ax, ay, az;
  logic         nx, ny, nz;
  logic         px, py, pz;
  cmfs_cell_t   sel;

  // magnitudes and signs; the most negative value stays exact
  always_comb begin
    ux = in_data.dir_x;
    uy = in_data.dir_y;
    uz = in_data.dir_z;
    nx = ux[C-1];
    ny = uy[C-1];
    nz = uz[C-1];
    ax = nx ? (~ux + 1'b1) : ux;
    ay = ny ? (~uy + 1'b1) : uy;
    az = nz ? (~uz + 1'b1) : uz;
    px = !nx && (ux != '0);
    py = !ny && (uy != '0);
    pz = !nz && (uz != '0);
  end

  // face pick, ties to x then y then z, with the sign table
  always_comb begin
    sel         = '0;
    sel.zero    = (ax == '0) && (ay == '0) && (az == '0);
    if (ax >= ay && ax >= az) begin
      sel.ma      = ax;
      sel.s.trial = az;
      sel.t.trial = ay;
      sel.t.neg   = py;
      if (!nx) begin
        sel.face  = FACE_POS_X;
        sel.s.neg = pz;
      end else begin
        sel.face  = FACE_NEG_X;
        sel.s.neg = nz;
      end
    end else if (ay >= az) begin
      sel.ma      = ay;
      sel.s.trial = ax;
      sel.s.neg   = nx;
      sel.t.trial = az;
      if (!ny) begin
        sel.face  = FACE_POS_Y;
        sel.t.neg = nz;
      end else begin
        sel.face  = FACE_NEG_Y;
        sel.t.neg = pz;
      end
    end else begin
      sel.ma      = az;
      sel.s.trial = ax;
      sel.t.trial = ay;
      sel.t.neg   = py;
      if (!nz) begin
        sel.face  = FACE_POS_Z;
        sel.s.neg = nx;
      end else begin
        sel.face  = FACE_NEG_Z;
        sel.s.neg = px;
      end
    end
  end

  // stage register, moves when downstream is empty or draining
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= sel;
    end
  end

endmodule

### rtl/cmfs_div_cell.sv
// ----------------------------------------------------------------------------
// cmfs_div_cell
// One restoring division step for both coordinate lanes against the shared
// major axis magnitude; yields one quotient bit per lane.
// ----------------------------------------------------------------------------
module cmfs_div_cell
  import cmfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  cmfs_cell_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output cmfs_cell_t out_data
);

  localparam int C = CMFS_COORD_BITS;
  localparam int F = CMFS_FRAC_BITS;

  logic         s_ge, t_ge;
  logic [C-1:0] s_rem, t_rem;
  cmfs_cell_t   step;

  // compare, subtract, shift remainder, shift in quotient bit
  always_comb begin
    s_ge  = in_data.s.trial >= in_data.ma;
    t_ge  = in_data.t.trial >= in_data.ma;
    s_rem = s_ge ? (in_data.s.trial - in_data.ma) : in_data.s.trial;
    t_rem = t_ge ? (in_data.t.trial - in_data.ma) : in_data.t.trial;
    step         = in_data;
    step.s.trial = {s_rem[C-2:0], 1'b0};
    step.t.trial = {t_rem[C-2:0], 1'b0};
    step.s.quo   = {in_data.s.quo[F-2:0], s_ge};
    step.t.quo   = {in_data.t.quo[F-2:0], t_ge};
  end

  // cell register
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= step;
    end
  end

endmodule

### rtl/cmfs_finish.sv
// ----------------------------------------------------------------------------
// cmfs_finish
// Turns quotient magnitudes into floored signed offsets around the face
// center, handles the zero vector, and holds the output register.
// ----------------------------------------------------------------------------
module cmfs_finish
  import cmfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  cmfs_cell_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output cmfs_out_t  out_data
);

  localparam int F = CMFS_FRAC_BITS;

  logic [F:0] s_mag, t_mag;
  cmfs_out_t  res;

  // negative quotients round away from zero when a remainder is left
  always_comb begin
    s_mag = {1'b0, in_data.s.quo} + (F+1)'(in_data.s.neg && (in_data.s.trial != '0));
    t_mag = {1'b0, in_data.t.quo} + (F+1)'(in_data.t.neg && (in_data.t.trial != '0));
    res.face        = in_data.face;
    res.zero_vector = in_data.zero;
    res.coord_s     = in_data.s.neg ? (CMFS_HALF - s_mag) : (CMFS_HALF + s_mag);
    res.coord_t     = in_data.t.neg ? (CMFS_HALF - t_mag) : (CMFS_HALF + t_mag);
    if (in_data.zero) begin
      res.face    = FACE_POS_X;
      res.coord_s = CMFS_HALF;
      res.coord_t = CMFS_HALF;
    end
  end

  // output register
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= res;
    end
  end

endmodule

### rtl/cube_map_face_select_unit.sv
// ----------------------------------------------------------------------------
// cube_map_face_select_unit
// Cube map face selection: major axis pick and per-face s,t coordinates,
// with the divisions done by a chain of one-bit restoring divider cells.
//
//   channel   signals                        payload
//   input     in_valid / in_ready            in_data  (cmfs_in_t)
//   output    out_valid / out_ready          out_data (cmfs_out_t)
//
// One transaction enters per cycle while the output is not stalled; the stages are
// one selection stage, one divider cell per quotient bit, and one output stage.
// Reset clears the valid bits of every stage; the data registers are not reset.
// Each stage holds while the next one is full and stalled, so bubbles in
// the chain are still filled while a result waits at the output.
// ----------------------------------------------------------------------------
module cube_map_face_select_unit
  import cmfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  cmfs_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output cmfs_out_t out_data
);

  localparam int F = CMFS_FRAC_BITS;

  logic       chain_valid [0:F];
  logic       chain_ready [0:F];
  cmfs_cell_t chain_data  [0:F];

  // axis selection
  cmfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar i = 0; i < F; i++) begin : g_cell
    cmfs_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  // rounding and output register
  cmfs_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[F]),
    .in_ready  (chain_ready[F]),
    .in_data   (chain_data[F]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // zero vector always yields the default face and center coordinates
  a_zero_default: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_vector |->
      out_data.face == FACE_POS_X && out_data.coord_s == CMFS_HALF &&
      out_data.coord_t == CMFS_HALF)
    else $error("zero vector result is not the default");

  // coordinates stay within the face span
  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.coord_s <= CMFS_ONE && out_data.coord_t <= CMFS_ONE)
    else $error("face coordinate out of range");

  // only the six face codes come out
  a_face_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.face <= FACE_NEG_Z)
    else $error("face code out of range");

  // no transaction survives reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !chain_valid[0])
    else $error("pipeline not empty after reset");

endmodule
